[sv/ipv4ofb_pkg.sv]
package ipv4ofb_pkg;

	typedef enum logic [3:0] {
		MODE_NOP        = 4'd0,
		MODE_END        = 4'd1,
		MODE_SECURITY   = 4'd2,
		MODE_ROUTE_HDR  = 4'd3,
		MODE_ROUTE_ADDR = 4'd4,
		MODE_STREAM_ID  = 4'd5,
		MODE_TIMESTAMP  = 4'd6,
		MODE_POP        = 4'd7,
		MODE_READ       = 4'd8
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_POP,
		ST_WRITE,
		ST_DONE
	} state_t;

	localparam int SIZE_W = 6;
	localparam int LEN_W  = 6;
	localparam int OPT_W  = 88;

	localparam logic [7:0] NOP_BYTE   = 8'd1;
	localparam logic [7:0] END_BYTE   = 8'd0;
	localparam logic [7:0] SEC_TYPE   = 8'd130;
	localparam logic [7:0] SEC_LEN    = 8'd11;
	localparam logic [7:0] SID_TYPE   = 8'd136;
	localparam logic [7:0] SID_LEN    = 8'd4;
	localparam logic [7:0] TS_TYPE    = 8'd68;
	localparam logic [7:0] TS_MIN_LEN = 8'd4;
	localparam logic [7:0] TS_MAX_LEN = 8'd40;
	localparam logic [7:0] TS_POINTER = 8'd5;

	localparam logic [3:0] TS_FLAG_ONLY    = 4'd0;
	localparam logic [3:0] TS_FLAG_ADDR    = 4'd1;
	localparam logic [3:0] TS_FLAG_PRESPEC = 4'd3;

	localparam logic [LEN_W-1:0] ONE_LEN        = 6'd1;
	localparam logic [LEN_W-1:0] ROUTE_HDR_LEN  = 6'd3;
	localparam logic [LEN_W-1:0] ROUTE_ADDR_LEN = 6'd4;

	// Input word, last field in the highest bits so it overlays s_tdata directly.
	typedef struct packed {
		logic [5:0]  read_index;
		logic [3:0]  ts_flag;
		logic [3:0]  route_count;
		logic [7:0]  hdr_pointer;
		logic [7:0]  hdr_length;
		logic [7:0]  hdr_type;
		logic [23:0] value_d;
		logic [15:0] value_c;
		logic [15:0] value_b;
		logic [31:0] value_a;
	} item_t;

	typedef struct packed {
		logic [5:0] option_count;
		logic [5:0] used_length;
		logic [7:0] read_byte;
		logic [7:0] popped_type;
		logic       accepted;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] len;
		logic [OPT_W-1:0] bytes;
	} wr_cmd_t;

endpackage

[sv/ipv4ofb_area.sv]
module ipv4ofb_area #(
	parameter int N = 40,
	localparam int AW = $clog2(N)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipv4ofb_pkg::wr_cmd_t  wr_cmd,
	input  logic [AW-1:0]         wr_base,
	output logic                  wr_busy,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [7:0]            rd_data
);
	import ipv4ofb_pkg::*;

	logic [7:0]       area_mem [N];
	logic [OPT_W-1:0] shift_q;
	logic [LEN_W-1:0] left_q;
	logic [AW-1:0]    addr_q;
	logic [7:0]       rd_data_q;

	assign wr_busy = (left_q != '0);
	assign rd_data = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (wr_cmd.start) begin
			left_q <= wr_cmd.len;
		end else if (wr_busy) begin
			left_q <= left_q - 1'b1;
		end
	end

	// Option bytes leave low byte first; zeros shift in, which pads timestamps.
	always_ff @(posedge clk) begin
		if (wr_cmd.start) begin
			shift_q <= wr_cmd.bytes;
			addr_q  <= wr_base;
		end else if (wr_busy) begin
			shift_q <= {8'd0, shift_q[OPT_W-1:8]};
			addr_q  <= addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_busy) begin
			area_mem[addr_q] <= shift_q[7:0];
		end
		if (rd_en) begin
			rd_data_q <= area_mem[rd_addr];
		end
	end

endmodule

[sv/ipv4ofb_ctrl.sv]
module ipv4ofb_ctrl #(
	parameter int N = 40,
	localparam int AW = $clog2(N),
	localparam int FW = $clog2(N + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ipv4ofb_pkg::mode_t    in_mode,
	input  ipv4ofb_pkg::item_t    in_item,
	output ipv4ofb_pkg::wr_cmd_t  wr_cmd,
	output logic [AW-1:0]         wr_base,
	input  logic                  wr_busy,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	input  logic [7:0]            rd_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output ipv4ofb_pkg::result_t  res
);
	import ipv4ofb_pkg::*;

	localparam int SW = ((FW > LEN_W) ? FW : LEN_W) + 1;
	localparam logic [SW-1:0] LIMIT = SW'(N);
	localparam logic [FW-1:0] CNT_LIMIT = FW'(N);

	state_t state_q, state_n;
	mode_t  mode_q;
	item_t  item_q;

	logic [FW-1:0] fill_q, count_q, fill_n, count_n;
	logic [3:0]    pending_q, pending_n;
	logic          ok_q, look_ok;
	logic [7:0]    popped_q, rbyte_q, look_rbyte;

	logic [SIZE_W-1:0] size_mem [N];
	logic [SIZE_W-1:0] size_rd_q, sz_wdata;
	logic [AW-1:0]     sz_waddr, sz_raddr;
	logic              sz_we, sz_re;

	logic             accept, go_write, go_pop;
	logic [LEN_W-1:0] cmd_len;
	logic [OPT_W-1:0] cmd_bytes;
	logic [FW-1:0]    pop_start;

	logic [SW-1:0] fill_x, rhdr_need;
	logic          cnt_free, fit_one, fit_sec, fit_sid, fit_rhdr, fit_raddr, fit_ts, ts_ok;

	assign accept    = in_valid && in_ready;
	assign pop_start = fill_q - FW'(size_rd_q);

	assign fill_x    = SW'(fill_q);
	assign rhdr_need = SW'(ROUTE_HDR_LEN) + (SW'(item_q.route_count) << 2);
	assign cnt_free  = count_q < CNT_LIMIT;
	assign fit_one   = cnt_free && (fill_x + SW'(ONE_LEN) <= LIMIT);
	assign fit_sec   = cnt_free && (fill_x + SW'(SEC_LEN) <= LIMIT);
	assign fit_sid   = cnt_free && (fill_x + SW'(SID_LEN) <= LIMIT);
	assign fit_rhdr  = cnt_free && (fill_x + rhdr_need <= LIMIT);
	assign fit_raddr = cnt_free && (count_q != '0) && (fill_x + SW'(ROUTE_ADDR_LEN) <= LIMIT);
	assign fit_ts    = cnt_free && (fill_x + SW'(item_q.hdr_length) <= LIMIT);
	assign ts_ok     = (item_q.ts_flag == TS_FLAG_ONLY || item_q.ts_flag == TS_FLAG_ADDR ||
			item_q.ts_flag == TS_FLAG_PRESPEC) &&
			item_q.hdr_length >= TS_MIN_LEN && item_q.hdr_length <= TS_MAX_LEN;

	// Decision taken in the look cycle, once the size of the last option is back.
	always_comb begin
		go_write   = 1'b0;
		go_pop     = 1'b0;
		look_ok    = 1'b0;
		look_rbyte = 8'd0;
		cmd_len    = '0;
		cmd_bytes  = '0;
		fill_n     = fill_q;
		count_n    = count_q;
		pending_n  = pending_q;
		sz_we      = 1'b0;
		sz_waddr   = AW'(count_q);
		sz_wdata   = '0;
		if (mode_q == MODE_READ) begin
			look_ok = SW'(item_q.read_index) < LIMIT;
			// Bytes past the used length always read as zero.
			if (SW'(item_q.read_index) < fill_x) begin
				look_rbyte = rd_data;
			end
		end else if (pending_q != '0) begin
			if (mode_q == MODE_ROUTE_ADDR && fit_raddr) begin
				go_write  = 1'b1;
				look_ok   = 1'b1;
				cmd_len   = ROUTE_ADDR_LEN;
				cmd_bytes = OPT_W'(item_q.value_a);
				fill_n    = fill_q + FW'(ROUTE_ADDR_LEN);
				pending_n = pending_q - 1'b1;
				sz_we     = 1'b1;
				sz_waddr  = AW'(count_q - 1'b1);
				sz_wdata  = size_rd_q + SIZE_W'(ROUTE_ADDR_LEN);
			end
		end else begin
			case (mode_q)
				MODE_NOP, MODE_END: begin
					if (fit_one) begin
						go_write  = 1'b1;
						cmd_len   = ONE_LEN;
						cmd_bytes = OPT_W'((mode_q == MODE_NOP) ? NOP_BYTE : END_BYTE);
					end
				end
				MODE_SECURITY: begin
					if (fit_sec) begin
						go_write  = 1'b1;
						cmd_len   = LEN_W'(SEC_LEN);
						cmd_bytes = {item_q.value_d, item_q.value_c, item_q.value_b,
								item_q.value_a[15:0], SEC_LEN, SEC_TYPE};
					end
				end
				MODE_ROUTE_HDR: begin
					if (fit_rhdr) begin
						go_write  = 1'b1;
						cmd_len   = ROUTE_HDR_LEN;
						cmd_bytes = OPT_W'({item_q.hdr_pointer, item_q.hdr_length,
								item_q.hdr_type});
						pending_n = item_q.route_count;
					end
				end
				MODE_STREAM_ID: begin
					if (fit_sid) begin
						go_write  = 1'b1;
						cmd_len   = LEN_W'(SID_LEN);
						cmd_bytes = OPT_W'({item_q.value_a[15:0], SID_LEN, SID_TYPE});
					end
				end
				MODE_TIMESTAMP: begin
					if (ts_ok && fit_ts) begin
						go_write  = 1'b1;
						cmd_len   = LEN_W'(item_q.hdr_length);
						cmd_bytes = OPT_W'({4'd0, item_q.ts_flag, TS_POINTER,
								item_q.hdr_length, TS_TYPE});
					end
				end
				MODE_POP: begin
					if (count_q != '0) begin
						go_pop  = 1'b1;
						look_ok = 1'b1;
						fill_n  = pop_start;
						count_n = count_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
			// Every append records a new entry in the size list.
			if (go_write) begin
				look_ok  = 1'b1;
				fill_n   = fill_q + FW'(cmd_len);
				count_n  = count_q + 1'b1;
				sz_we    = 1'b1;
				sz_wdata = SIZE_W'(cmd_len);
			end
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_n = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (go_write) begin
					state_n = ST_WRITE;
				end else if (go_pop) begin
					state_n = ST_POP;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_POP: begin
				state_n = ST_DONE;
			end
			ST_WRITE: begin
				// Interlock: the next item is not taken before the last byte is in.
				if (!wr_busy) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		res_valid    = (state_q == ST_DONE);
		wr_cmd.start = (state_q == ST_LOOK) && go_write;
		wr_cmd.len   = cmd_len;
		wr_cmd.bytes = cmd_bytes;
		wr_base      = AW'(fill_q);
		sz_re        = accept;
		sz_raddr     = (count_q == '0) ? '0 : AW'(count_q - 1'b1);
		if (state_q == ST_LOOK) begin
			rd_en   = go_pop;
			rd_addr = AW'(pop_start);
		end else begin
			rd_en   = accept;
			rd_addr = AW'(in_item.read_index);
		end
		res.accepted     = ok_q;
		res.popped_type  = popped_q;
		res.read_byte    = rbyte_q;
		res.used_length  = 6'(fill_q);
		res.option_count = 6'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			count_q   <= '0;
			pending_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_LOOK) begin
				fill_q    <= fill_n;
				count_q   <= count_n;
				pending_q <= pending_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= in_mode;
			item_q   <= in_item;
			popped_q <= 8'd0;
		end
		if (state_q == ST_LOOK) begin
			ok_q    <= look_ok;
			rbyte_q <= look_rbyte;
		end
		if (state_q == ST_POP) begin
			popped_q <= rd_data;
		end
	end

	always_ff @(posedge clk) begin
		if (sz_we && state_q == ST_LOOK) begin
			size_mem[sz_waddr] <= sz_wdata;
		end
		if (sz_re) begin
			size_rd_q <= size_mem[sz_raddr];
		end
	end

endmodule

[sv/ipv4_option_field_builder.sv]
// IPv4 options assembler. Each input word appends one option (or one route address) to
// an options area of OPTION_AREA_BYTES bytes, pops the last option, or reads one byte
// of the area, and every word gives exactly one result word with the accept flag, the
// popped first byte, the read byte and the new used length and option count. Words
// are taken one at a time. The area lives in a byte memory with one write and one read
// port that is filled one byte per cycle; an append passes through the look and write
// states, a pop through look and pop, and a read or a rejected word through look alone,
// before the result word. The option sizes sit in a second memory that is read back in
// the cycle after acceptance. No clearing pass follows reset: bytes past the used
// length always read as zero.
module ipv4_option_field_builder #(
	parameter int OPTION_AREA_BYTES = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// value_a, value_b, value_c, value_d, hdr_type, hdr_length, hdr_pointer,
	// route_count, ts_flag, read_index
	input  logic [127:0] s_tdata,
	// mode
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// accepted, popped_type, read_byte, used_length, option_count
	output logic [31:0]  m_tdata
);
	import ipv4ofb_pkg::*;

	localparam int AW = $clog2(OPTION_AREA_BYTES);

	wr_cmd_t       wr_cmd;
	logic [AW-1:0] wr_base, rd_addr;
	logic          wr_busy, rd_en;
	logic [7:0]    rd_data;
	logic          res_valid, res_ready;
	result_t       res, res_q;
	logic          m_tvalid_q;

	ipv4ofb_area #(.N(OPTION_AREA_BYTES)) u_area (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_cmd  (wr_cmd),
		.wr_base (wr_base),
		.wr_busy (wr_busy),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ipv4ofb_ctrl #(.N(OPTION_AREA_BYTES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (mode_t'(s_tuser)),
		.in_item   (item_t'(s_tdata[$bits(item_t)-1:0])),
		.wr_cmd    (wr_cmd),
		.wr_base   (wr_base),
		.wr_busy   (wr_busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The result register lets the controller take the next word while a result waits.
	assign res_ready = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {3'd0, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
			m_tvalid && !res_q.accepted |-> res_q.popped_type == 8'd0 &&
			res_q.read_byte == 8'd0)
		else $error("rejected word carries data");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
			wr_busy |-> !s_tready && !res_valid)
		else $error("word taken or answered while option bytes are written");

	a_empty_area: assert property (@(posedge clk) disable iff (!arst_n)
			m_tvalid && res_q.option_count == 6'd0 |-> res_q.used_length == 6'd0)
		else $error("bytes in use with no option stored");
`endif

endmodule

[bench/ipv4_option_field_builder_test.sv]
`timescale 1ns / 100ps

module ipv4_option_field_builder_test;
	import ipv4ofb_pkg::*;

	localparam int AREA = 40;
	localparam int RANDOM_WORDS = 750;
	localparam int LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int QUIET_FIRST = 300;
	localparam int QUIET_LAST = 420;
	localparam int HOLD_AT = 500;
	localparam logic [3:0] MODE_UNUSED_BASE = 4'd9;
	localparam logic [3:0] MODE_UNUSED_TOP = 4'd15;

	typedef struct {
		logic [3:0] mode;
		item_t      word;
		bit         typed;
		result_t    want;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [3:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic         quiet_phase;

	// Model of the options area.
	logic [7:0]  area_bytes [AREA];
	logic [5:0]  area_sizes [AREA];
	int unsigned fill_len;
	int unsigned opt_count;
	int unsigned routes_left;

	result_t     expected_results [$];
	stim_row_t   directed_rows [$];
	int          errors;
	int          cycles;
	result_t     got;
	result_t     want;

	ipv4_option_field_builder #(
		.OPTION_AREA_BYTES(AREA)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	function automatic bit has_room(input int unsigned n);
		return fill_len + n <= AREA && opt_count < AREA;
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		if (fill_len < AREA) begin
			area_bytes[fill_len] = b;
			fill_len++;
		end
	endfunction

	function automatic void push_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			push_byte(v[8*i +: 8]);
	endfunction

	function automatic void note_size(input int unsigned size);
		if (opt_count < AREA) begin
			area_sizes[opt_count] = 6'(size);
			opt_count++;
		end
	endfunction

	// Applies one input word to the area model and returns the result word it gives.
	function automatic result_t apply_option_word(input logic [3:0] mode, input item_t w);
		result_t r;
		int unsigned sz;
		int unsigned start;
		r = '0;
		if (mode == MODE_READ) begin
			if (w.read_index < AREA) begin
				r.read_byte = area_bytes[w.read_index];
				r.accepted = 1'b1;
			end
		end else if (routes_left != 0) begin
			// A source route is open: only its addresses may go in.
			if (mode == MODE_ROUTE_ADDR && has_room(0) && fill_len + ROUTE_ADDR_LEN <= AREA
					&& opt_count > 0) begin
				push_le(w.value_a, 4);
				area_sizes[opt_count - 1] = area_sizes[opt_count - 1] + ROUTE_ADDR_LEN;
				routes_left--;
				r.accepted = 1'b1;
			end
		end else begin
			case (mode)
				MODE_NOP, MODE_END: begin
					if (has_room(ONE_LEN)) begin
						push_byte(mode == MODE_NOP ? NOP_BYTE : END_BYTE);
						note_size(ONE_LEN);
						r.accepted = 1'b1;
					end
				end
				MODE_SECURITY: begin
					if (has_room(SEC_LEN)) begin
						push_byte(SEC_TYPE);
						push_byte(SEC_LEN);
						push_le(w.value_a, 2);
						push_le(w.value_b, 2);
						push_le(w.value_c, 2);
						push_le(w.value_d, 3);
						note_size(SEC_LEN);
						r.accepted = 1'b1;
					end
				end
				MODE_ROUTE_HDR: begin
					if (has_room(ROUTE_HDR_LEN + ROUTE_ADDR_LEN * w.route_count)) begin
						push_byte(w.hdr_type);
						push_byte(w.hdr_length);
						push_byte(w.hdr_pointer);
						note_size(ROUTE_HDR_LEN);
						routes_left = w.route_count;
						r.accepted = 1'b1;
					end
				end
				MODE_STREAM_ID: begin
					if (has_room(SID_LEN)) begin
						push_byte(SID_TYPE);
						push_byte(SID_LEN);
						push_le(w.value_a, 2);
						note_size(SID_LEN);
						r.accepted = 1'b1;
					end
				end
				MODE_TIMESTAMP: begin
					if ((w.ts_flag == TS_FLAG_ONLY || w.ts_flag == TS_FLAG_ADDR
							|| w.ts_flag == TS_FLAG_PRESPEC)
							&& w.hdr_length >= TS_MIN_LEN && w.hdr_length <= TS_MAX_LEN
							&& has_room(w.hdr_length)) begin
						push_byte(TS_TYPE);
						push_byte(w.hdr_length);
						push_byte(TS_POINTER);
						push_byte({4'd0, w.ts_flag});
						for (int i = TS_MIN_LEN; i < w.hdr_length; i++)
							push_byte(8'd0);
						note_size(w.hdr_length);
						r.accepted = 1'b1;
					end
				end
				MODE_POP: begin
					if (opt_count > 0) begin
						sz = area_sizes[opt_count - 1];
						start = sz <= fill_len ? fill_len - sz : 0;
						if (start < AREA)
							r.popped_type = area_bytes[start];
						for (int unsigned i = start; i < fill_len && i < AREA; i++)
							area_bytes[i] = 8'd0;
						fill_len = start;
						area_sizes[opt_count - 1] = '0;
						opt_count--;
						r.accepted = 1'b1;
					end
				end
				default: ;
			endcase
		end
		r.used_length = 6'(fill_len);
		r.option_count = 6'(opt_count);
		return r;
	endfunction

	function automatic stim_row_t make_row(input logic [3:0] mode, input logic [31:0] va,
			input logic [15:0] vb, input logic [15:0] vc, input logic [23:0] vd,
			input logic [7:0] ht, input logic [7:0] hl, input logic [7:0] hp,
			input logic [3:0] rc, input logic [3:0] fl, input logic [5:0] ri);
		stim_row_t r;
		r.mode = mode;
		r.word = '{read_index: ri, ts_flag: fl, route_count: rc, hdr_pointer: hp,
			hdr_length: hl, hdr_type: ht, value_d: vd, value_c: vc, value_b: vb,
			value_a: va};
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input stim_row_t r, input logic acc,
			input logic [7:0] popped, input logic [7:0] rb, input logic [5:0] used,
			input logic [5:0] cnt);
		r.typed = 1'b1;
		r.want = '{option_count: cnt, used_length: used, read_byte: rb,
			popped_type: popped, accepted: acc};
		return r;
	endfunction

	// Draws one random word. Open source routes are mostly fed their addresses.
	task automatic pick_random_word(output logic [3:0] mode, output item_t w);
		logic [127:0] noise;
		int roll;
		int pop_share;
		noise = {$urandom(), $urandom(), $urandom(), $urandom()};
		w = noise[$bits(item_t)-1:0];
		w.route_count = 4'($urandom_range(0, 9));
		roll = $urandom_range(0, 99);
		if (routes_left != 0) begin
			if (roll < 85)
				mode = MODE_ROUTE_ADDR;
			else if (roll < 93)
				mode = MODE_READ;
			else
				mode = 4'($urandom_range(0, 15));
		end else begin
			pop_share = fill_len > 28 ? 35 : 10;
			if (roll < pop_share) begin
				mode = MODE_POP;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 8)
					mode = MODE_NOP;
				else if (roll < 14)
					mode = MODE_END;
				else if (roll < 29)
					mode = MODE_SECURITY;
				else if (roll < 44)
					mode = MODE_ROUTE_HDR;
				else if (roll < 56)
					mode = MODE_STREAM_ID;
				else if (roll < 76)
					mode = MODE_TIMESTAMP;
				else if (roll < 94)
					mode = MODE_READ;
				else if (roll < 97)
					mode = MODE_ROUTE_ADDR;
				else
					mode = 4'($urandom_range(MODE_UNUSED_BASE, MODE_UNUSED_TOP));
			end
		end
		case (mode)
			MODE_ROUTE_HDR: begin
				if ($urandom_range(0, 3) != 0)
					w.route_count = 4'($urandom_range(0, 3));
			end
			MODE_TIMESTAMP: begin
				if ($urandom_range(0, 99) < 85) begin
					case ($urandom_range(0, 2))
						0: w.ts_flag = TS_FLAG_ONLY;
						1: w.ts_flag = TS_FLAG_ADDR;
						default: w.ts_flag = TS_FLAG_PRESPEC;
					endcase
					if ($urandom_range(0, 9) == 0)
						w.hdr_length = 8'($urandom_range(TS_MIN_LEN, TS_MAX_LEN));
					else
						w.hdr_length = 8'($urandom_range(TS_MIN_LEN, 12));
				end
			end
			MODE_READ: begin
				if ($urandom_range(0, 9) != 0)
					w.read_index = 6'($urandom_range(0, AREA - 1));
			end
			default: ;
		endcase
	endtask

	task automatic send_word(input logic [3:0] mode, input item_t w, input bit typed,
			input result_t typed_want);
		result_t predicted;
		if (!quiet_phase && $urandom_range(0, 99) < 6) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= 128'(w);
		s_tuser <= mode;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = apply_option_word(mode, w);
		expected_results.push_back(typed ? typed_want : predicted);
	endtask

	task automatic wait_for_results;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(result_t)-1:0];
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result word 0x%h with nothing expected", m_tdata));
			end else begin
				want = expected_results.pop_front();
				if (got.accepted !== want.accepted)
					report_mismatch($sformatf("accepted %0d, want %0d",
						got.accepted, want.accepted));
				if (got.popped_type !== want.popped_type)
					report_mismatch($sformatf("popped_type %0d, want %0d",
						got.popped_type, want.popped_type));
				if (got.read_byte !== want.read_byte)
					report_mismatch($sformatf("read_byte %0d, want %0d",
						got.read_byte, want.read_byte));
				if (got.used_length !== want.used_length)
					report_mismatch($sformatf("used_length %0d, want %0d",
						got.used_length, want.used_length));
				if (got.option_count !== want.option_count)
					report_mismatch($sformatf("option_count %0d, want %0d",
						got.option_count, want.option_count));
			end
		end
		m_tready <= quiet_phase || ($urandom_range(0, 99) >= 6);
	end

	initial begin
		logic [3:0] mode;
		item_t      w;
		stim_row_t  row;
		errors = 0;
		cycles = 0;
		fill_len = 0;
		opt_count = 0;
		routes_left = 0;
		for (int i = 0; i < AREA; i++) begin
			area_bytes[i] = 8'd0;
			area_sizes[i] = '0;
		end
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= MODE_NOP;
		m_tready <= 1'b0;
		quiet_phase <= 1'b0;

		// Reads, rejections on an empty area, then a chain of options that ends
		// exactly at the area boundary.
		directed_rows.push_back(typed_row(make_row(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, 0, 0, 0, 0));
		directed_rows.push_back(typed_row(make_row(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 40),
			0, 0, 0, 0, 0));
		directed_rows.push_back(typed_row(make_row(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 63),
			0, 0, 0, 0, 0));
		directed_rows.push_back(typed_row(make_row(MODE_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			0, 0, 0, 0, 0));
		directed_rows.push_back(typed_row(make_row(MODE_ROUTE_ADDR, 32'hFFFF_FFFF, 0, 0, 0,
			0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
		directed_rows.push_back(typed_row(make_row(MODE_UNUSED_TOP, 0, 0, 0, 0, 0, 0, 0, 0,
			0, 0), 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(MODE_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(MODE_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_row(MODE_SECURITY, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			24'hFF_FFFF, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(typed_row(make_row(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2),
			1, 0, SEC_TYPE, 13, 3));
		directed_rows.push_back(make_row(MODE_STREAM_ID, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0,
			0, 0));
		directed_rows.push_back(typed_row(make_row(MODE_TIMESTAMP, 0, 0, 0, 0, 0, 8, 0, 0,
			4'd2, 0), 0, 0, 0, 17, 4));
		directed_rows.push_back(typed_row(make_row(MODE_TIMESTAMP, 0, 0, 0, 0, 0, 3, 0, 0,
			TS_FLAG_ONLY, 0), 0, 0, 0, 17, 4));
		directed_rows.push_back(typed_row(make_row(MODE_TIMESTAMP, 0, 0, 0, 0, 0, 41, 0, 0,
			TS_FLAG_ADDR, 0), 0, 0, 0, 17, 4));
		directed_rows.push_back(make_row(MODE_TIMESTAMP, 0, 0, 0, 0, 0, 4, 0, 0,
			TS_FLAG_PRESPEC, 0));
		directed_rows.push_back(typed_row(make_row(MODE_ROUTE_HDR, 0, 0, 0, 0, 8'h83, 8'hFF,
			8'h04, 9, 0, 0), 0, 0, 0, 21, 5));
		directed_rows.push_back(make_row(MODE_ROUTE_HDR, 0, 0, 0, 0, 8'h83, 8'd11, 8'hFF, 2,
			0, 0));
		directed_rows.push_back(typed_row(make_row(MODE_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			0, 0, 0, 24, 6));
		directed_rows.push_back(make_row(MODE_ROUTE_ADDR, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0,
			0, 0));
		directed_rows.push_back(typed_row(make_row(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 21),
			1, 0, 8'h83, 28, 6));
		directed_rows.push_back(make_row(MODE_ROUTE_ADDR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed_rows.push_back(typed_row(make_row(MODE_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, 8'h83, 0, 21, 5));
		directed_rows.push_back(make_row(MODE_TIMESTAMP, 0, 0, 0, 0, 0, 19, 0, 0,
			TS_FLAG_ONLY, 0));
		directed_rows.push_back(typed_row(make_row(MODE_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			0, 0, 0, 40, 6));
		directed_rows.push_back(typed_row(make_row(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 39),
			1, 0, 0, 40, 6));
		directed_rows.push_back(typed_row(make_row(MODE_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, TS_TYPE, 0, 21, 5));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_word(row.mode, row.word, row.typed, row.want);
		end
		s_tvalid <= 1'b0;
		wait_for_results();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			quiet_phase <= n >= QUIET_FIRST && n < QUIET_LAST;
			if (n == HOLD_AT) begin
				s_tvalid <= 1'b0;
				wait_for_results();
			end
			pick_random_word(mode, w);
			send_word(mode, w, 1'b0, '0);
		end
		s_tvalid <= 1'b0;
		quiet_phase <= 1'b0;

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
